FILE: rtl/core/pdrx_pkg.sv
// shared types, constants and crc helper for the pd receive message checker
package pdrx_pkg;

  localparam logic [31:0] CrcPoly     = 32'hEDB88320;
  localparam logic [31:0] CrcInit     = 32'hFFFFFFFF;
  localparam int unsigned HdrBytes    = 2;
  localparam int unsigned BytesPerObj = 4;
  localparam int unsigned CrcBytes    = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;  // input transfer this cycle
    logic emit_next;  // output transfer this cycle
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic msg_done;   // byte being taken closes a message with a result
    logic emit_last;  // result on the output is the final one
  } sts_t;

  // reflected crc-32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/pdrx_ctrl.sv
// controller: byte intake and result emission sequencing
module pdrx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pdrx_pkg::sts_t sts_i,
  output pdrx_pkg::cmd_t cmd_o
);
  import pdrx_pkg::*;

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;

  assign in_ready_o  = (state_q == ST_RUN);
  assign out_valid_o = (state_q == ST_EMIT);

  assign cmd_o.take_byte = in_valid_i & in_ready_o;
  assign cmd_o.emit_next = out_valid_o & out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (cmd_o.take_byte && sts_i.msg_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit_next && sts_i.emit_last) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/pdrx_datapath.sv
// datapath: header capture, crc, object store and result fields
module pdrx_datapath #(
  parameter int unsigned MAX_DATA_OBJECTS = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdrx_pkg::cmd_t cmd_i,
  input  logic [7:0]     data_byte_i,
  input  logic           packet_start_i,
  output pdrx_pkg::sts_t sts_o,
  output logic           kind_o,
  output logic           status_o,
  output logic [4:0]     message_type_o,
  output logic           host_role_o,
  output logic [1:0]     spec_revision_o,
  output logic           src_role_o,
  output logic [2:0]     message_id_o,
  output logic [2:0]     object_count_o,
  output logic [2:0]     object_index_o,
  output logic [31:0]    object_value_o,
  output logic           last_o
);
  import pdrx_pkg::*;

  localparam logic [3:0] MaxObj = 4'(MAX_DATA_OBJECTS);

  logic        in_q, in_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] hdr_q, hdr_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_q, rx_d;
  logic [31:0] store_q [MAX_DATA_OBJECTS];
  logic        res_err_q;
  logic [2:0]  eidx_q;
  logic [31:0] rd_val_q;

  logic        eff_in;
  logic [5:0]  eff_pos;
  logic [15:0] eff_hdr;
  logic [31:0] eff_crc;
  logic [31:0] eff_rx;
  logic [2:0]  cnt;
  logic [5:0]  data_end;
  logic [5:0]  crc_end;
  logic [5:0]  off;
  logic [5:0]  rx_off;
  logic        st_wr;
  logic        done;
  logic        err;
  logic [2:0]  res_cnt;

  // a start mark restarts the message on this very byte
  assign eff_in  = packet_start_i | in_q;
  assign eff_pos = packet_start_i ? 6'd0 : pos_q;
  assign eff_hdr = packet_start_i ? 16'd0 : hdr_q;
  assign eff_crc = packet_start_i ? CrcInit : crc_q;
  assign eff_rx  = packet_start_i ? 32'd0 : rx_q;

  assign cnt      = eff_hdr[14:12];
  assign data_end = 6'(HdrBytes) + {1'b0, cnt, 2'b00};
  assign crc_end  = data_end + 6'(CrcBytes - 1);
  assign off      = eff_pos - 6'(HdrBytes);
  assign rx_off   = eff_pos - data_end;

  always_comb begin
    in_d  = in_q;
    pos_d = pos_q;
    hdr_d = hdr_q;
    crc_d = crc_q;
    rx_d  = rx_q;
    st_wr = 1'b0;
    done  = 1'b0;
    err   = 1'b0;
    if (cmd_i.take_byte) begin
      in_d  = eff_in;
      pos_d = eff_pos;
      hdr_d = eff_hdr;
      crc_d = eff_crc;
      rx_d  = eff_rx;
      if (eff_in) begin
        pos_d = eff_pos + 6'd1;
        if (eff_pos < 6'(HdrBytes)) begin
          if (eff_pos[0]) begin
            hdr_d[15:8] = data_byte_i;
          end else begin
            hdr_d[7:0] = data_byte_i;
          end
          crc_d = crc_byte(eff_crc, data_byte_i);
          // count too large for the object store
          if (eff_pos[0] && ({1'b0, data_byte_i[6:4]} > MaxObj)) begin
            in_d = 1'b0;
            done = 1'b1;
            err  = 1'b1;
          end
        end else if (eff_pos < data_end) begin
          st_wr = 1'b1;
          crc_d = crc_byte(eff_crc, data_byte_i);
        end else begin
          rx_d[8*rx_off[1:0] +: 8] = data_byte_i;
          if (eff_pos == crc_end) begin
            in_d = 1'b0;
            done = 1'b1;
            err  = (~eff_crc) != {data_byte_i, eff_rx[23:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q      <= 1'b0;
      pos_q     <= '0;
      hdr_q     <= '0;
      crc_q     <= CrcInit;
      rx_q      <= '0;
      res_err_q <= 1'b0;
      eidx_q    <= '0;
    end else begin
      in_q  <= in_d;
      pos_q <= pos_d;
      hdr_q <= hdr_d;
      crc_q <= crc_d;
      rx_q  <= rx_d;
      if (done) begin
        res_err_q <= err;
        eidx_q    <= '0;
      end else if (cmd_i.emit_next) begin
        eidx_q <= eidx_q + 3'd1;
      end
    end
  end

  // object store, byte lane writes; the next object is fetched on each result transfer
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < MAX_DATA_OBJECTS; e++) begin
      if (st_wr && (off[4:2] == 3'(e))) begin
        store_q[e][8*off[1:0] +: 8] <= data_byte_i;
      end
    end
    if (done) begin
      rd_val_q <= '0;
    end else if (cmd_i.emit_next) begin
      for (int e = 0; e < MAX_DATA_OBJECTS; e++) begin
        if (eidx_q == 3'(e)) rd_val_q <= store_q[e];
      end
    end
  end

  assign res_cnt = hdr_q[14:12];

  assign kind_o          = (eidx_q != 3'd0);
  assign status_o        = res_err_q;
  assign message_type_o  = res_err_q ? 5'd0 : hdr_q[4:0];
  assign host_role_o     = res_err_q ? 1'b0 : hdr_q[5];
  assign spec_revision_o = res_err_q ? 2'd0 : hdr_q[7:6];
  assign src_role_o      = res_err_q ? 1'b0 : hdr_q[8];
  assign message_id_o    = res_err_q ? 3'd0 : hdr_q[11:9];
  assign object_count_o  = res_err_q ? 3'd0 : res_cnt;
  assign object_index_o  = (eidx_q == 3'd0) ? 3'd0 : (eidx_q - 3'd1);
  assign object_value_o  = (eidx_q == 3'd0) ? 32'd0 : rd_val_q;
  assign last_o          = res_err_q | (eidx_q == res_cnt);

  assign sts_o.msg_done  = done;
  assign sts_o.emit_last = last_o;

endmodule

FILE: rtl/core/usb_pd_rx_message_checker_unit.sv
// top level of the usb pd receive message checker with crc-32 check
// throughput: one message byte per cycle while no results are pending
// latency: first result is valid the cycle after the final crc byte transfer
// a good message with n objects gives 1 + n results, one per cycle while out_ready_i is high, input held off meanwhile
// byte intake is set by the byte-wide crc update, emission by the single result register
// reset: async active low, clears message state and crc; the object store is not cleared
module usb_pd_rx_message_checker_unit #(
  parameter int unsigned MAX_DATA_OBJECTS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic        status_o,
  output logic [4:0]  message_type_o,
  output logic        host_role_o,
  output logic [1:0]  spec_revision_o,
  output logic        src_role_o,
  output logic [2:0]  message_id_o,
  output logic [2:0]  object_count_o,
  output logic [2:0]  object_index_o,
  output logic [31:0] object_value_o,
  output logic        last_o
);
  import pdrx_pkg::*;

  cmd_t cmd;  // transfer strobes from the controller
  sts_t sts;  // message end and last result flags

  // sequencing: takes bytes, then walks the result burst
  pdrx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // header, crc, object store and result fields
  pdrx_datapath #(
    .MAX_DATA_OBJECTS (MAX_DATA_OBJECTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .data_byte_i     (data_byte_i),
    .packet_start_i  (packet_start_i),
    .sts_o           (sts),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .message_type_o  (message_type_o),
    .host_role_o     (host_role_o),
    .spec_revision_o (spec_revision_o),
    .src_role_o      (src_role_o),
    .message_id_o    (message_id_o),
    .object_count_o  (object_count_o),
    .object_index_o  (object_index_o),
    .object_value_o  (object_value_o),
    .last_o          (last_o)
  );

`ifndef SYNTH
  // intake and emission never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("intake and emission active together");

  // a burst keeps going until its last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("result burst ended early");

  // intake resumes right after the last result transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("intake not resumed after last result");

  // an error result stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && !kind_o)
    else $error("error result not single");

  // object results stay within the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> object_index_o < object_count_o)
    else $error("object index beyond count");
`endif

endmodule

FILE: dv/tb_usb_pd_rx_message_checker_unit.sv
// testbench for the usb pd receive message checker: framed messages against a byte-level predictor
module tb_usb_pd_rx_message_checker_unit;

  localparam int unsigned MaxObjects    = 7;
  localparam logic [31:0] CrcPolyRefl   = 32'hEDB88320;
  localparam logic [31:0] CrcSeed       = 32'hFFFFFFFF;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned BytesPerPhase = 35;

  // one result as the block presents it
  typedef struct packed {
    logic        kind;
    logic        status;
    logic [4:0]  message_type;
    logic        host_role;
    logic [1:0]  spec_revision;
    logic        src_role;
    logic [2:0]  message_id;
    logic [2:0]  object_count;
    logic [2:0]  object_index;
    logic [31:0] object_value;
    logic        last;
  } pd_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        packet_start_i = 1'b0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic        status_o;
  logic [4:0]  message_type_o;
  logic        host_role_o;
  logic [1:0]  spec_revision_o;
  logic        src_role_o;
  logic [2:0]  message_id_o;
  logic [2:0]  object_count_o;
  logic [2:0]  object_index_o;
  logic [31:0] object_value_o;
  logic        last_o;

  usb_pd_rx_message_checker_unit #(
    .MAX_DATA_OBJECTS(MaxObjects)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .message_type_o (message_type_o),
    .host_role_o    (host_role_o),
    .spec_revision_o(spec_revision_o),
    .src_role_o     (src_role_o),
    .message_id_o   (message_id_o),
    .object_count_o (object_count_o),
    .object_index_o (object_index_o),
    .object_value_o (object_value_o),
    .last_o         (last_o)
  );

  // receive-side message tracking, mirrors the block after reset
  logic        rx_open     = 1'b0;
  int unsigned rx_pos      = 0;
  logic [15:0] rx_header   = '0;
  logic [31:0] rx_crc_acc  = CrcSeed;
  logic [31:0] rx_crc_word = '0;
  logic [31:0] rx_objects [MaxObjects];

  // results predicted but not yet seen on the output
  pd_result_t  due_results [$];

  // frame under construction by the stimulus
  logic [31:0] frame_objs [MaxObjects];
  logic [7:0]  frame_q [$];

  int send_idle_pct = 30;
  int recv_idle_pct = 60;
  int err_count     = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int frames_good   = 0;
  int frames_bad    = 0;
  int frames_cut    = 0;
  int stall_cycles  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_refl_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    return c;
  endfunction

  // advance the tracked message by one accepted byte and queue whatever results it closes
  function automatic void track_rx_byte(input logic [7:0] b, input logic st);
    logic [2:0]  cnt;
    int unsigned data_end;
    int unsigned off;
    pd_result_t  r;
    // a start mark always opens a fresh message, dropping any open one silently
    if (st) begin
      rx_open     = 1'b1;
      rx_pos      = 0;
      rx_header   = '0;
      rx_crc_acc  = CrcSeed;
      rx_crc_word = '0;
    end
    // bytes outside a message are ignored
    if (!rx_open) return;

    if (rx_pos < 2) begin
      rx_header[8*rx_pos +: 8] = b;
      rx_crc_acc = crc32_refl_step(rx_crc_acc, b);
      rx_pos++;
      // object count above the store depth closes the message with an error
      if (rx_pos == 2 && rx_header[14:12] > MaxObjects) begin
        rx_open  = 1'b0;
        r        = '0;
        r.status = 1'b1;
        r.last   = 1'b1;
        due_results.push_back(r);
      end
      return;
    end

    cnt      = rx_header[14:12];
    data_end = 2 + 4 * cnt;
    if (rx_pos < data_end) begin
      off = rx_pos - 2;
      rx_objects[off / 4][8*(off % 4) +: 8] = b;
      rx_crc_acc = crc32_refl_step(rx_crc_acc, b);
      rx_pos++;
      return;
    end

    // trailing crc, little endian
    rx_crc_word[8*((rx_pos - data_end) % 4) +: 8] = b;
    rx_pos++;
    if (rx_pos < data_end + 4) return;

    rx_open = 1'b0;
    if (~rx_crc_acc != rx_crc_word) begin
      r        = '0;
      r.status = 1'b1;
      r.last   = 1'b1;
      due_results.push_back(r);
      return;
    end
    r               = '0;
    r.message_type  = rx_header[4:0];
    r.host_role     = rx_header[5];
    r.spec_revision = rx_header[7:6];
    r.src_role      = rx_header[8];
    r.message_id    = rx_header[11:9];
    r.object_count  = cnt;
    r.last          = (cnt == 0);
    due_results.push_back(r);
    // data objects repeat the header fields
    for (int unsigned i = 0; i < cnt; i++) begin
      r.kind         = 1'b1;
      r.object_index = 3'(i);
      r.object_value = rx_objects[i];
      r.last         = (i + 1 == cnt);
      due_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // one byte transfer on the input channel, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    packet_start_i <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_rx_byte(b, st);
    bytes_sent++;
  endtask

  // build header, objects and crc; optionally flip one bit or cut the frame short
  task automatic send_frame(input logic [15:0] hdr, input int flip_bit, input int cut_len);
    logic [31:0] acc;
    int          n;
    int          i;
    int          k;
    frame_q.delete();
    frame_q.push_back(hdr[7:0]);
    frame_q.push_back(hdr[15:8]);
    for (i = 0; i < hdr[14:12]; i++)
      for (k = 0; k < 4; k++) frame_q.push_back(frame_objs[i][8*k +: 8]);
    acc = CrcSeed;
    foreach (frame_q[j]) acc = crc32_refl_step(acc, frame_q[j]);
    acc = ~acc;
    for (k = 0; k < 4; k++) frame_q.push_back(acc[8*k +: 8]);
    if (flip_bit >= 0)
      frame_q[flip_bit / 8] = frame_q[flip_bit / 8] ^ (8'd1 << (flip_bit % 8));
    n = (cut_len > 0) ? cut_len : frame_q.size();
    for (i = 0; i < n; i++) send_byte(frame_q[i], i == 0);
    if (cut_len > 0) frames_cut++;
    else if (flip_bit >= 0) frames_bad++;
    else frames_good++;
  endtask

  // stray byte with no message open gives nothing
  task automatic test_outside_bytes();
    send_byte(8'hFF, 1'b0);
  endtask

  // restart right after the header, before any data byte, then the full frame with extreme object values
  task automatic test_restart_and_objects();
    frame_objs[0] = 32'hFFFFFFFF;
    frame_objs[1] = 32'h00000000;
    send_frame(16'hAFFF, -1, 2);
    send_frame(16'hAFFF, -1, 0);
  endtask

  // empty message with an all-zero header, then one with a broken crc
  task automatic test_empty_and_bad_crc();
    send_frame(16'h0000, -1, 0);
    send_frame(16'h0FFF, 40, 0);
  endtask

  // mostly clean frames with random content, plus corrupted, truncated and noise traffic
  task automatic test_random_traffic(input int sp, input int rp);
    int          stop_at;
    int          pick;
    int          len;
    int          i;
    logic [15:0] hdr;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    stop_at = bytes_sent + BytesPerPhase;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      hdr  = 16'($urandom);
      // small counts dominate, the full store shows up now and then
      hdr[14:12] = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
      for (i = 0; i < MaxObjects; i++) frame_objs[i] = $urandom;
      len = 6 + 4 * hdr[14:12];
      if (pick < 65) send_frame(hdr, -1, 0);
      else if (pick < 80) send_frame(hdr, $urandom_range(8 * len - 1, 16), 0);
      else if (pick < 90) send_frame(hdr, -1, $urandom_range(len - 1, 1));
      else repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare every output transfer with the oldest prediction
  always @(posedge clk_i) begin
    pd_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(kind_o), 32'd0);
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind)
          report_mismatch("kind", 32'(kind_o), 32'(want.kind));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (message_type_o !== want.message_type)
          report_mismatch("message_type", 32'(message_type_o), 32'(want.message_type));
        if (host_role_o !== want.host_role)
          report_mismatch("host_role", 32'(host_role_o), 32'(want.host_role));
        if (spec_revision_o !== want.spec_revision)
          report_mismatch("spec_revision", 32'(spec_revision_o), 32'(want.spec_revision));
        if (src_role_o !== want.src_role)
          report_mismatch("src_role", 32'(src_role_o), 32'(want.src_role));
        if (message_id_o !== want.message_id)
          report_mismatch("message_id", 32'(message_id_o), 32'(want.message_id));
        if (object_count_o !== want.object_count)
          report_mismatch("object_count", 32'(object_count_o), 32'(want.object_count));
        if (object_index_o !== want.object_index)
          report_mismatch("object_index", 32'(object_index_o), 32'(want.object_index));
        if (object_value_o !== want.object_value)
          report_mismatch("object_value", object_value_o, want.object_value);
        if (last_o !== want.last)
          report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // watchdog: cycles with work pending but no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else if (in_valid_i || due_results.size() != 0) stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, due_results.size());
      $display("tb_usb_pd_rx_message_checker_unit: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_outside_bytes();
    test_restart_and_objects();
    test_empty_and_bad_crc();
    test_random_traffic(30, 60);
    test_random_traffic(60, 30);
    test_random_traffic(0, 0);

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // let any stray late result show up
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes: %0d clean frames, %0d with a flipped bit, %0d cut short",
             bytes_sent, frames_good, frames_bad, frames_cut);
    $display("compared %0d results, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("tb_usb_pd_rx_message_checker_unit: PASS");
    end else begin
      $display("tb_usb_pd_rx_message_checker_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pdrx_pkg.sv
rtl/core/pdrx_ctrl.sv
rtl/core/pdrx_datapath.sv
rtl/core/usb_pd_rx_message_checker_unit.sv
dv/tb_usb_pd_rx_message_checker_unit.sv
